FILE: design/swp_pkg.sv
// Shared types, constants and helpers for the swirl warp address generator.
package swp_pkg;

    // Field and register widths.
    localparam int COORD_BITS_DEF = 12;
    localparam int CTR_W          = 16;
    localparam int ANG_W          = 16;
    localparam int RAD_W          = 17;
    localparam int DIM_W          = 13;
    localparam int CFG_DATA_W     = 17;
    localparam int CFG_IDX_W      = 4;
    localparam int RSQ_W          = 2 * RAD_W;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    // Iteration counts of the pipelined arithmetic units.
    localparam int SQRT_STEPS   = RAD_W;
    localparam int DIV_STEPS    = 16;
    localparam int CORDIC_STEPS = 16;

    // Angle arithmetic in Q.16 radians.
    localparam int ANGQ_W = 21;
    localparam logic signed [ANGQ_W-1:0] PI_Q16      = 21'sd205887;
    localparam logic signed [ANGQ_W-1:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [ANGQ_W-1:0] TWO_PI_Q16  = 21'sd411775;

    // CORDIC datapath in Q.30, cosine and sine in Q.16.
    localparam int XY_W = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam int CS_W = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X     = 4'd0,
        CFG_CENTER_Y     = 4'd1,
        CFG_MAX_ANGLE    = 4'd2,
        CFG_INNER_RADIUS = 4'd3,
        CFG_PEAK_RADIUS  = 4'd4,
        CFG_OUTER_RADIUS = 4'd5,
        CFG_IMAGE_WIDTH  = 4'd6,
        CFG_IMAGE_HEIGHT = 4'd7
    } cfg_idx_t;

    // Radial zone of a destination pixel.
    typedef enum logic [1:0] {
        ZONE_IDENT = 2'd0,
        ZONE_RISE  = 2'd1,
        ZONE_FALL  = 2'd2
    } zone_t;

    typedef struct packed {
        logic [CTR_W-1:0]        center_x;
        logic [CTR_W-1:0]        center_y;
        logic signed [ANG_W-1:0] max_angle;
        logic [RAD_W-1:0]        inner_radius;
        logic [RAD_W-1:0]        peak_radius;
        logic [RAD_W-1:0]        outer_radius;
        logic [DIM_W-1:0]        image_width;
        logic [DIM_W-1:0]        image_height;
    } cfg_t;

    // Width of the signed offset from the centre, 4 fraction bits.
    function automatic int dist_w(input int cb);
        return ((cb + 4) > CTR_W ? cb + 4 : CTR_W) + 1;
    endfunction

    // Width of one queue entry: zone, pixel, offsets and squared distance.
    function automatic int entry_w(input int cb);
        return 2 + 2 * cb + 2 * dist_w(cb) + RSQ_W;
    endfunction

    // Arctangent of 2^-step in Q.16.
    function automatic logic signed [ANGQ_W-1:0] cordic_step_angle(input int step);
        logic signed [ANGQ_W-1:0] ang;
        case (step)
            0:       ang = 21'sd51472;
            1:       ang = 21'sd30386;
            2:       ang = 21'sd16055;
            3:       ang = 21'sd8150;
            4:       ang = 21'sd4091;
            5:       ang = 21'sd2047;
            6:       ang = 21'sd1024;
            7:       ang = 21'sd512;
            8:       ang = 21'sd256;
            9:       ang = 21'sd128;
            10:      ang = 21'sd64;
            11:      ang = 21'sd32;
            12:      ang = 21'sd16;
            13:      ang = 21'sd8;
            14:      ang = 21'sd4;
            15:      ang = 21'sd2;
            default: ang = 21'sd0;
        endcase
        return ang;
    endfunction

endpackage

FILE: design/swirl_warp_address_gen_top.sv
// Swirl warp address generator top level: register file, front end, queue and back end.
// Takes one destination pixel per clock unless in_stall is raised, and returns one source address per item, in order,
// after 3 front stages, the queue, 58 back stages and the output register. Sustained throughput is
// one item per clock while the output is not stalled: the square root (17
// stages), the angle divider (16 stages) and the CORDIC rotator (16 stages) are all fully
// pipelined, and the four-entry queue lets the front end keep taking items until it fills
// while the output is stalled. Registers are to be written through the configuration port only
// while the block holds no items; the block itself does not enforce this, and cfg_ready is always high.
module swirl_warp_address_gen_top #(
    parameter int COORD_BITS = swp_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [COORD_BITS-1:0]           dest_x,
    input  logic [COORD_BITS-1:0]           dest_y,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [COORD_BITS-1:0]           src_x,
    output logic [COORD_BITS-1:0]           src_y,
    output logic                            inside_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ENTRY_W = swp_pkg::entry_w(COORD_BITS);

    swp_pkg::cfg_t     cfg_reg;
    logic              q_push, q_full, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    // Register file writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= '0;
            cfg_reg.center_y     <= '0;
            cfg_reg.max_angle    <= '0;
            cfg_reg.inner_radius <= '0;
            cfg_reg.peak_radius  <= '0;
            cfg_reg.outer_radius <= '0;
            cfg_reg.image_width  <= swp_pkg::WIDTH_RST;
            cfg_reg.image_height <= swp_pkg::HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (swp_pkg::cfg_idx_t'(cfg_index))
                swp_pkg::CFG_CENTER_X:     cfg_reg.center_x     <= cfg_data[swp_pkg::CTR_W-1:0];
                swp_pkg::CFG_CENTER_Y:     cfg_reg.center_y     <= cfg_data[swp_pkg::CTR_W-1:0];
                swp_pkg::CFG_MAX_ANGLE:    cfg_reg.max_angle    <= cfg_data[swp_pkg::ANG_W-1:0];
                swp_pkg::CFG_INNER_RADIUS: cfg_reg.inner_radius <= cfg_data[swp_pkg::RAD_W-1:0];
                swp_pkg::CFG_PEAK_RADIUS:  cfg_reg.peak_radius  <= cfg_data[swp_pkg::RAD_W-1:0];
                swp_pkg::CFG_OUTER_RADIUS: cfg_reg.outer_radius <= cfg_data[swp_pkg::RAD_W-1:0];
                swp_pkg::CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[swp_pkg::DIM_W-1:0];
                swp_pkg::CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[swp_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    swp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dest_x   (dest_x),
        .dest_y   (dest_y),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    swp_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (swp_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_rdata)
    );

    swp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .src_x      (src_x),
        .src_y      (src_y),
        .inside_res (inside_res)
    );

endmodule

FILE: design/swp_fifo.sv
// Short queue between the classifying front end and the warp back end.
module swp_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = swp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill level; the depth is a power of two so pointers wrap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill level did not advance on a write");

endmodule

FILE: design/swp_front.sv
// Front end: accepts destination pixels, measures squared distance, picks the zone.
module swp_front #(
    parameter int COORD_BITS = swp_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swp_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] dest_x,
    input  logic [COORD_BITS-1:0] dest_y,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [swp_pkg::entry_w(COORD_BITS)-1:0] q_data
);

    localparam int DW    = swp_pkg::dist_w(COORD_BITS);
    localparam int PW    = 2 * DW - 2;
    localparam int SW    = PW + 1;
    localparam int CMP_W = (SW > swp_pkg::RSQ_W) ? SW : swp_pkg::RSQ_W;

    logic fen;

    logic                  v1_reg, v2_reg, v3_reg;
    logic [COORD_BITS-1:0] px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic signed [DW-1:0]  dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic [PW-1:0]         sqx2_reg, sqy2_reg;
    logic [SW-1:0]         s3_reg;

    logic [swp_pkg::RSQ_W-1:0] in2_reg, pk2_reg, out2_reg;

    logic signed [DW-1:0]   dx_next, dy_next;
    logic signed [2*DW-1:0] prod_x, prod_y;
    logic [CMP_W-1:0]       s_ext, in2_ext, pk2_ext, out2_ext;
    swp_pkg::zone_t         zone;

    // The whole front end moves together whenever the queue has room.
    assign fen      = !q_full;
    assign in_stall = !fen;

    // Offsets from the centre with 4 fraction bits.
    assign dx_next = $signed(DW'({dest_x, 4'h0})) - $signed(DW'(cfg.center_x));
    assign dy_next = $signed(DW'({dest_y, 4'h0})) - $signed(DW'(cfg.center_y));

    assign prod_x = dx1_reg * dx1_reg;
    assign prod_y = dy1_reg * dy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (fen)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            px1_reg  <= dest_x;
            py1_reg  <= dest_y;
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            sqx2_reg <= prod_x[PW-1:0];
            sqy2_reg <= prod_y[PW-1:0];
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            s3_reg   <= SW'(sqx2_reg) + SW'(sqy2_reg);
        end
    end

    // Squared radii follow the registers; the user must hold them still while items are in flight (not enforced here).
    always_ff @(posedge clk)
    begin
        in2_reg  <= swp_pkg::RSQ_W'(cfg.inner_radius) * swp_pkg::RSQ_W'(cfg.inner_radius);
        pk2_reg  <= swp_pkg::RSQ_W'(cfg.peak_radius) * swp_pkg::RSQ_W'(cfg.peak_radius);
        out2_reg <= swp_pkg::RSQ_W'(cfg.outer_radius) * swp_pkg::RSQ_W'(cfg.outer_radius);
    end

    // Zone choice on the squared distance, tested in order.
    assign s_ext    = CMP_W'(s3_reg);
    assign in2_ext  = CMP_W'(in2_reg);
    assign pk2_ext  = CMP_W'(pk2_reg);
    assign out2_ext = CMP_W'(out2_reg);

    always_comb
    begin
        if (s_ext <= in2_ext)
        begin
            zone = swp_pkg::ZONE_IDENT;
        end
        else if (s_ext <= pk2_ext)
        begin
            zone = swp_pkg::ZONE_RISE;
        end
        else if (s_ext < out2_ext)
        begin
            zone = swp_pkg::ZONE_FALL;
        end
        else
        begin
            zone = swp_pkg::ZONE_IDENT;
        end
    end

    assign q_push = fen && v3_reg;
    assign q_data = {zone, px3_reg, py3_reg, dx3_reg, dy3_reg, s_ext[swp_pkg::RSQ_W-1:0]};

endmodule

FILE: design/swp_back.sv
// Back end: square root, angle divide, CORDIC rotation, rounding and bounds check.
module swp_back #(
    parameter int COORD_BITS = swp_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swp_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    input  logic [swp_pkg::entry_w(COORD_BITS)-1:0] q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] src_x,
    output logic [COORD_BITS-1:0] src_y,
    output logic                  inside_res
);

    localparam int DW      = swp_pkg::dist_w(COORD_BITS);
    localparam int ENTRY_W = swp_pkg::entry_w(COORD_BITS);
    localparam int SIDE_W  = ENTRY_W - swp_pkg::RSQ_W;
    localparam int SQ_W    = swp_pkg::RSQ_W + 1;
    localparam int PROD_W  = swp_pkg::ANG_W + swp_pkg::RAD_W + 2;
    localparam int MAG_W   = PROD_W - 1;
    localparam int N_W     = MAG_W + 2;
    localparam int D_W     = swp_pkg::RAD_W + 1;
    localparam int Q_W     = swp_pkg::DIV_STEPS;
    localparam int MP_W    = swp_pkg::CS_W + DW;
    localparam int SM_W    = MP_W + 2;
    localparam int RW      = SM_W - 19;

    // Stage positions along the back pipeline.
    localparam int ST_SQ   = 0;
    localparam int ST_NUM  = ST_SQ + swp_pkg::SQRT_STEPS;
    localparam int ST_PREP = ST_NUM + 1;
    localparam int ST_DIV  = ST_PREP + 1;
    localparam int ST_ANG  = ST_DIV + swp_pkg::DIV_STEPS;
    localparam int ST_RED1 = ST_ANG + 1;
    localparam int ST_RED2 = ST_RED1 + 1;
    localparam int ST_COR  = ST_RED2 + 1;
    localparam int ST_CS   = ST_COR + swp_pkg::CORDIC_STEPS;
    localparam int ST_MUL  = ST_CS + 1;
    localparam int ST_SUM  = ST_MUL + 1;
    localparam int ST_RND  = ST_SUM + 1;
    localparam int NST     = ST_RND + 1;

    logic en;
    logic out_valid_reg;

    logic              vld_reg  [NST];
    logic [SIDE_W-1:0] side_reg [NST];

    // The pipeline advances unless a finished result is held by the receiver.
    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= q_valid;
            for (int k = 1; k < NST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Zone, pixel and offsets ride along with each item.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= q_data[ENTRY_W-1 -: SIDE_W];
            for (int k = 1; k < NST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Integer square root, one result bit per stage.
    logic [SQ_W-1:0] sq_v_reg [swp_pkg::SQRT_STEPS];
    logic [SQ_W-1:0] sq_r_reg [swp_pkg::SQRT_STEPS];

    for (genvar j = 0; j < swp_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        logic [SQ_W-1:0] v_in, r_in, bitv, trial;
        if (j == 0)
        begin : g_first
            assign v_in = SQ_W'(q_data[swp_pkg::RSQ_W-1:0]);
            assign r_in = '0;
        end
        else
        begin : g_next
            assign v_in = sq_v_reg[j-1];
            assign r_in = sq_r_reg[j-1];
        end
        assign bitv  = SQ_W'(1) << (2 * (swp_pkg::SQRT_STEPS - 1 - j));
        assign trial = r_in + bitv;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= trial)
                begin
                    sq_v_reg[j] <= v_in - trial;
                    sq_r_reg[j] <= (r_in >> 1) + bitv;
                end
                else
                begin
                    sq_v_reg[j] <= v_in;
                    sq_r_reg[j] <= r_in >> 1;
                end
            end
        end
    end

    // Angle numerator and denominator for the rising or falling ramp.
    logic [swp_pkg::RAD_W-1:0] root_r;
    logic [swp_pkg::RAD_W:0]   num_diff, num_den;
    swp_pkg::zone_t            num_zone;
    logic signed [PROD_W-1:0]  num_prod_reg;
    logic [swp_pkg::RAD_W-1:0] num_den_reg;

    assign root_r   = sq_r_reg[swp_pkg::SQRT_STEPS-1][swp_pkg::RAD_W-1:0];
    assign num_zone = swp_pkg::zone_t'(side_reg[ST_NUM-1][SIDE_W-1 -: 2]);

    always_comb
    begin
        case (num_zone)
            swp_pkg::ZONE_RISE:
            begin
                num_diff = {1'b0, root_r} - {1'b0, cfg.inner_radius};
                num_den  = {1'b0, cfg.peak_radius} - {1'b0, cfg.inner_radius};
            end
            swp_pkg::ZONE_FALL:
            begin
                num_diff = {1'b0, cfg.outer_radius} - {1'b0, root_r};
                num_den  = {1'b0, cfg.outer_radius} - {1'b0, cfg.peak_radius};
            end
            default:
            begin
                num_diff = '0;
                num_den  = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_prod_reg <= $signed(PROD_W'(cfg.max_angle)) * $signed(PROD_W'(num_diff));
            num_den_reg  <= num_den[swp_pkg::RAD_W-1:0];
        end
    end

    // Round-half-away division set up as floor((2|n| + d) / 2d).
    logic             prep_neg;
    logic [MAG_W-1:0] prep_mag;
    logic [N_W-1:0]   prep_rem_reg;
    logic [D_W-1:0]   prep_d_reg;
    logic             prep_neg_reg;

    assign prep_neg = num_prod_reg[PROD_W-1];
    assign prep_mag = prep_neg ? MAG_W'(-num_prod_reg) : MAG_W'(num_prod_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_rem_reg <= {1'b0, prep_mag, 1'b0} + N_W'(num_den_reg);
            prep_d_reg   <= {num_den_reg, 1'b0};
            prep_neg_reg <= prep_neg;
        end
    end

    // Restoring divider, one quotient bit per stage.
    logic [N_W-1:0] div_rem_reg [swp_pkg::DIV_STEPS];
    logic [D_W-1:0] div_d_reg   [swp_pkg::DIV_STEPS];
    logic [Q_W-1:0] div_q_reg   [swp_pkg::DIV_STEPS];
    logic           div_neg_reg [swp_pkg::DIV_STEPS];

    for (genvar i = 0; i < swp_pkg::DIV_STEPS; i++)
    begin : g_div
        logic [N_W-1:0] rem_in, shd;
        logic [D_W-1:0] d_in;
        logic [Q_W-1:0] q_in;
        logic           neg_in;
        if (i == 0)
        begin : g_first
            assign rem_in = prep_rem_reg;
            assign d_in   = prep_d_reg;
            assign q_in   = '0;
            assign neg_in = prep_neg_reg;
        end
        else
        begin : g_next
            assign rem_in = div_rem_reg[i-1];
            assign d_in   = div_d_reg[i-1];
            assign q_in   = div_q_reg[i-1];
            assign neg_in = div_neg_reg[i-1];
        end
        assign shd = N_W'(d_in) << (swp_pkg::DIV_STEPS - 1 - i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_d_reg[i]   <= d_in;
                div_neg_reg[i] <= neg_in;
                if (rem_in >= shd)
                begin
                    div_rem_reg[i] <= rem_in - shd;
                    div_q_reg[i]   <= q_in | (Q_W'(1) << (swp_pkg::DIV_STEPS - 1 - i));
                end
                else
                begin
                    div_rem_reg[i] <= rem_in;
                    div_q_reg[i]   <= q_in;
                end
            end
        end
    end

    // Signed angle in Q.16, then folded into [-pi/2, pi/2] with a flip flag.
    logic signed [swp_pkg::ANGQ_W-1:0] ang_mag;
    logic signed [swp_pkg::ANGQ_W-1:0] ang_a_reg, red1_a_reg, red2_a_reg;
    logic                              red2_flip_reg;

    assign ang_mag = $signed(swp_pkg::ANGQ_W'(div_q_reg[swp_pkg::DIV_STEPS-1]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_a_reg <= (div_neg_reg[swp_pkg::DIV_STEPS-1] ? -ang_mag : ang_mag) <<< 4;

            if (ang_a_reg > swp_pkg::PI_Q16)
            begin
                red1_a_reg <= ang_a_reg - swp_pkg::TWO_PI_Q16;
            end
            else if (ang_a_reg < -swp_pkg::PI_Q16)
            begin
                red1_a_reg <= ang_a_reg + swp_pkg::TWO_PI_Q16;
            end
            else
            begin
                red1_a_reg <= ang_a_reg;
            end

            if (red1_a_reg > swp_pkg::HALF_PI_Q16)
            begin
                red2_a_reg    <= red1_a_reg - swp_pkg::PI_Q16;
                red2_flip_reg <= 1'b1;
            end
            else if (red1_a_reg < -swp_pkg::HALF_PI_Q16)
            begin
                red2_a_reg    <= red1_a_reg + swp_pkg::PI_Q16;
                red2_flip_reg <= 1'b1;
            end
            else
            begin
                red2_a_reg    <= red1_a_reg;
                red2_flip_reg <= 1'b0;
            end
        end
    end

    // CORDIC rotation, one micro-rotation per stage.
    logic signed [swp_pkg::XY_W-1:0]   cor_x_reg    [swp_pkg::CORDIC_STEPS];
    logic signed [swp_pkg::XY_W-1:0]   cor_y_reg    [swp_pkg::CORDIC_STEPS];
    logic signed [swp_pkg::ANGQ_W-1:0] cor_a_reg    [swp_pkg::CORDIC_STEPS];
    logic                              cor_flip_reg [swp_pkg::CORDIC_STEPS];

    for (genvar i = 0; i < swp_pkg::CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [swp_pkg::XY_W-1:0]   x_in, y_in, xs, ys;
        logic signed [swp_pkg::ANGQ_W-1:0] a_in;
        logic                              flip_in;
        if (i == 0)
        begin : g_first
            assign x_in    = swp_pkg::CORDIC_GAIN_Q30;
            assign y_in    = '0;
            assign a_in    = red2_a_reg;
            assign flip_in = red2_flip_reg;
        end
        else
        begin : g_next
            assign x_in    = cor_x_reg[i-1];
            assign y_in    = cor_y_reg[i-1];
            assign a_in    = cor_a_reg[i-1];
            assign flip_in = cor_flip_reg[i-1];
        end
        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cor_flip_reg[i] <= flip_in;
                if (!a_in[swp_pkg::ANGQ_W-1])
                begin
                    cor_x_reg[i] <= x_in - ys;
                    cor_y_reg[i] <= y_in + xs;
                    cor_a_reg[i] <= a_in - swp_pkg::cordic_step_angle(i);
                end
                else
                begin
                    cor_x_reg[i] <= x_in + ys;
                    cor_y_reg[i] <= y_in - xs;
                    cor_a_reg[i] <= a_in + swp_pkg::cordic_step_angle(i);
                end
            end
        end
    end

    // Cosine and sine rounded to Q.16, negated when the angle was flipped.
    localparam int LAST_C = swp_pkg::CORDIC_STEPS - 1;
    logic signed [swp_pkg::XY_W-1:0] c_full, s_full;
    logic signed [swp_pkg::CS_W-1:0] c_rnd, s_rnd;
    logic signed [swp_pkg::CS_W-1:0] cs_c_reg, cs_s_reg;

    assign c_full = (cor_x_reg[LAST_C] + swp_pkg::XY_W'(8192)) >>> 14;
    assign s_full = (cor_y_reg[LAST_C] + swp_pkg::XY_W'(8192)) >>> 14;
    assign c_rnd  = c_full[swp_pkg::CS_W-1:0];
    assign s_rnd  = s_full[swp_pkg::CS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_c_reg <= cor_flip_reg[LAST_C] ? -c_rnd : c_rnd;
            cs_s_reg <= cor_flip_reg[LAST_C] ? -s_rnd : s_rnd;
        end
    end

    // Rotation products.
    logic signed [DW-1:0]   mul_dx, mul_dy;
    logic signed [MP_W-1:0] mul_cx_reg, mul_sy_reg, mul_sx_reg, mul_cy_reg;

    assign mul_dx = side_reg[ST_MUL-1][2*DW-1 -: DW];
    assign mul_dy = side_reg[ST_MUL-1][DW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_cx_reg <= cs_c_reg * mul_dx;
            mul_sy_reg <= cs_s_reg * mul_dy;
            mul_sx_reg <= cs_s_reg * mul_dx;
            mul_cy_reg <= cs_c_reg * mul_dy;
        end
    end

    // Source position in Q.20 about the centre.
    logic signed [SM_W-1:0] sum_x_reg, sum_y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_x_reg <= $signed(SM_W'(cfg.center_x) << 16)
                         + SM_W'(mul_cx_reg) - SM_W'(mul_sy_reg);
            sum_y_reg <= $signed(SM_W'(cfg.center_y) << 16)
                         + SM_W'(mul_sx_reg) + SM_W'(mul_cy_reg);
        end
    end

    // Round half away from zero, or pass the pixel through in the identity zone.
    logic signed [SM_W-1:0] rnd_px, rnd_nx, rnd_py, rnd_ny;
    logic signed [RW-1:0]   rnd_sx, rnd_sy;
    logic signed [RW-1:0]   rnd_sx_reg, rnd_sy_reg;
    swp_pkg::zone_t         rnd_zone;
    logic [COORD_BITS-1:0]  rnd_pix_x, rnd_pix_y;

    assign rnd_px = (sum_x_reg + SM_W'(1 << 19)) >>> 20;
    assign rnd_nx = -((-sum_x_reg + SM_W'(1 << 19)) >>> 20);
    assign rnd_py = (sum_y_reg + SM_W'(1 << 19)) >>> 20;
    assign rnd_ny = -((-sum_y_reg + SM_W'(1 << 19)) >>> 20);
    assign rnd_sx = sum_x_reg[SM_W-1] ? rnd_nx[RW-1:0] : rnd_px[RW-1:0];
    assign rnd_sy = sum_y_reg[SM_W-1] ? rnd_ny[RW-1:0] : rnd_py[RW-1:0];

    assign rnd_zone  = swp_pkg::zone_t'(side_reg[ST_RND-1][SIDE_W-1 -: 2]);
    assign rnd_pix_x = side_reg[ST_RND-1][SIDE_W-3 -: COORD_BITS];
    assign rnd_pix_y = side_reg[ST_RND-1][SIDE_W-3-COORD_BITS -: COORD_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rnd_zone == swp_pkg::ZONE_IDENT)
            begin
                rnd_sx_reg <= $signed(RW'(rnd_pix_x));
                rnd_sy_reg <= $signed(RW'(rnd_pix_y));
            end
            else
            begin
                rnd_sx_reg <= rnd_sx;
                rnd_sy_reg <= rnd_sy;
            end
        end
    end

    // Bounds check against the image, limited to the coordinate field.
    logic [RW-1:0] field_lim, lim_w, lim_h;
    logic          in_img;
    logic [COORD_BITS-1:0] src_x_reg, src_y_reg;
    logic          inside_reg;

    assign field_lim = RW'(1) << COORD_BITS;
    assign lim_w     = (RW'(cfg.image_width) < field_lim) ? RW'(cfg.image_width) : field_lim;
    assign lim_h     = (RW'(cfg.image_height) < field_lim) ? RW'(cfg.image_height) : field_lim;
    assign in_img    = !rnd_sx_reg[RW-1] && ($unsigned(rnd_sx_reg) < lim_w)
                    && !rnd_sy_reg[RW-1] && ($unsigned(rnd_sy_reg) < lim_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= in_img;
            src_x_reg  <= in_img ? rnd_sx_reg[COORD_BITS-1:0] : '0;
            src_y_reg  <= in_img ? rnd_sy_reg[COORD_BITS-1:0] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign inside_res = inside_reg;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the swirl warp address generator.
`timescale 1ns / 1ps

module tb_top;

    localparam int CB = swp_pkg::COORD_BITS_DEF;
    localparam longint FIELD_LIM = longint'(1) << CB;
    localparam int COORD_MAX = int'(FIELD_LIM) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 200;
    localparam logic [swp_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd12;

    typedef struct {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
    } pixel_t;

    typedef struct {
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic          ins;
    } src_addr_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [CB-1:0] dest_x;
    logic [CB-1:0] dest_y;
    logic out_valid;
    logic out_stall;
    logic [CB-1:0] src_x;
    logic [CB-1:0] src_y;
    logic inside_res;
    logic cfg_valid;
    logic cfg_ready;
    logic [swp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [swp_pkg::CFG_DATA_W-1:0] cfg_data;

    pixel_t    pixel_q[$];
    src_addr_t src_addr_q[$];
    int errors;
    int cycles;

    // Shadow copy of the configuration registers.
    longint sh_cx, sh_cy, sh_angle, sh_inner, sh_peak, sh_outer, sh_width, sh_height;

    swirl_warp_address_gen_top #(.COORD_BITS(CB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .dest_x(dest_x), .dest_y(dest_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .src_x(src_x), .src_y(src_y), .inside_res(inside_res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Integer square root, rounded down.
    function automatic longint isqrt(input longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Division rounded half away from zero, positive divisor.
    function automatic longint div_half_away(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint round_q20(input longint v);
        if (v >= 0)
        begin
            return (v + (longint'(1) << 19)) >>> 20;
        end
        return -((-v + (longint'(1) << 19)) >>> 20);
    endfunction

    // Rotation by CORDIC: Q3.12 angle in, cosine and sine in Q.16 out.
    task automatic rotate_cos_sin(input longint ang_q12, output longint c, output longint s);
        longint atan_q16 [16];
        longint a;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit flip;
        atan_q16 = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
        a = ang_q12 * 16;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (a > 205887)
        begin
            a = a - 411775;
        end
        else if (a < -205887)
        begin
            a = a + 411775;
        end
        if (a > 102944)
        begin
            a = a - 205887;
            flip = 1'b1;
        end
        else if (a < -102944)
        begin
            a = a + 205887;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0)
            begin
                x = x - ys;
                y = y + xs;
                a = a - atan_q16[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                a = a + atan_q16[i];
            end
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endtask

    // Source address of one destination pixel under the current configuration.
    task automatic warp_source(input pixel_t p, output src_addr_t r);
        longint dx;
        longint dy;
        longint sq;
        longint rad;
        longint ang;
        longint c;
        longint s;
        longint sx;
        longint sy;
        longint lim_w;
        longint lim_h;
        bit turn;
        bit ins;
        dx = longint'(p.px) * 16 - sh_cx;
        dy = longint'(p.py) * 16 - sh_cy;
        sq = dx * dx + dy * dy;
        sx = longint'(p.px);
        sy = longint'(p.py);
        turn = 1'b0;
        ang = 0;
        if (sq <= sh_inner * sh_inner)
        begin
            turn = 1'b0;
        end
        else if (sq <= sh_peak * sh_peak)
        begin
            rad = isqrt(sq);
            ang = div_half_away(sh_angle * (rad - sh_inner), sh_peak - sh_inner);
            turn = 1'b1;
        end
        else if (sq < sh_outer * sh_outer)
        begin
            rad = isqrt(sq);
            ang = div_half_away(sh_angle * (sh_outer - rad), sh_outer - sh_peak);
            turn = 1'b1;
        end
        if (turn)
        begin
            rotate_cos_sin(ang, c, s);
            sx = round_q20(sh_cx * 65536 + c * dx - s * dy);
            sy = round_q20(sh_cy * 65536 + s * dx + c * dy);
        end
        lim_w = (sh_width < FIELD_LIM) ? sh_width : FIELD_LIM;
        lim_h = (sh_height < FIELD_LIM) ? sh_height : FIELD_LIM;
        ins = (sx >= 0) && (sx < lim_w) && (sy >= 0) && (sy < lim_h);
        r.sx = ins ? sx[CB-1:0] : '0;
        r.sy = ins ? sy[CB-1:0] : '0;
        r.ins = ins;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Sender: bursts of items with random gaps; predicts each accepted item.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t p;
        pixel_t acc;
        src_addr_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            dest_x <= '0;
            dest_y <= '0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                acc.px = dest_x;
                acc.py = dest_y;
                warp_source(acc, r);
                src_addr_q.push_back(r);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() > 0)
                begin
                    p = pixel_q.pop_front();
                    dest_x <= p.px;
                    dest_y <= p.py;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= int'($urandom_range(1, 24));
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0
                                    : int'($urandom_range(1, 8));
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode, plus one long hold-off on request.
    logic hold_go;
    logic hold_done;
    int hold_left;
    int mode_left;
    int stall_pct;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
            mode_left <= 0;
            stall_pct <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left <= int'($urandom_range(20, 80));
                case ($urandom_range(0, 2))
                    0: stall_pct <= 0;
                    1: stall_pct <= 30;
                    default: stall_pct <= 70;
                endcase
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            if (hold_go && !hold_done && hold_left == 0)
            begin
                hold_left <= 400;
                hold_done <= 1'b1;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= (int'($urandom_range(0, 99)) < stall_pct);
            end
        end
    end

    // Checker: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        src_addr_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (src_addr_q.size() == 0)
            begin
                $display("MISMATCH: result with no item outstanding at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                want = src_addr_q.pop_front();
                if (src_x !== want.sx)
                begin
                    report("src_x", longint'(src_x), longint'(want.sx));
                end
                if (src_y !== want.sy)
                begin
                    report("src_y", longint'(src_y), longint'(want.sy));
                end
                if (inside_res !== want.ins)
                begin
                    report("inside_res", longint'(inside_res), longint'(want.ins));
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [swp_pkg::CFG_IDX_W-1:0] idx, input longint value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[swp_pkg::CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            swp_pkg::CFG_CENTER_X:     sh_cx = longint'(value[swp_pkg::CTR_W-1:0]);
            swp_pkg::CFG_CENTER_Y:     sh_cy = longint'(value[swp_pkg::CTR_W-1:0]);
            swp_pkg::CFG_MAX_ANGLE:    sh_angle = longint'($signed(value[swp_pkg::ANG_W-1:0]));
            swp_pkg::CFG_INNER_RADIUS: sh_inner = longint'(value[swp_pkg::RAD_W-1:0]);
            swp_pkg::CFG_PEAK_RADIUS:  sh_peak = longint'(value[swp_pkg::RAD_W-1:0]);
            swp_pkg::CFG_OUTER_RADIUS: sh_outer = longint'(value[swp_pkg::RAD_W-1:0]);
            swp_pkg::CFG_IMAGE_WIDTH:  sh_width = longint'(value[swp_pkg::DIM_W-1:0]);
            swp_pkg::CFG_IMAGE_HEIGHT: sh_height = longint'(value[swp_pkg::DIM_W-1:0]);
            default:
            begin
            end
        endcase
    endtask

    task automatic write_all(input longint cx, cy, ang, inner, peak, outer, w, h);
        cfg_write(swp_pkg::CFG_CENTER_X, cx);
        cfg_write(swp_pkg::CFG_CENTER_Y, cy);
        cfg_write(swp_pkg::CFG_MAX_ANGLE, ang);
        cfg_write(swp_pkg::CFG_INNER_RADIUS, inner);
        cfg_write(swp_pkg::CFG_PEAK_RADIUS, peak);
        cfg_write(swp_pkg::CFG_OUTER_RADIUS, outer);
        cfg_write(swp_pkg::CFG_IMAGE_WIDTH, w);
        cfg_write(swp_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic push_pixel(input int x, input int y);
        pixel_t p;
        p.px = CB'(x);
        p.py = CB'(y);
        pixel_q.push_back(p);
    endtask

    // Mostly pixels around the swirl, the rest anywhere in the field.
    task automatic push_random_pixels(input int n);
        int cxp;
        int cyp;
        int span;
        int x;
        int y;
        cxp = int'(sh_cx >>> 4);
        cyp = int'(sh_cy >>> 4);
        span = int'((sh_outer > sh_peak ? sh_outer : sh_peak) / 16) + 3;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                x = cxp + int'($urandom_range(0, 2 * span)) - span;
                y = cyp + int'($urandom_range(0, 2 * span)) - span;
                x = x < 0 ? 0 : (x > COORD_MAX ? COORD_MAX : x);
                y = y < 0 ? 0 : (y > COORD_MAX ? COORD_MAX : y);
            end
            else
            begin
                x = int'($urandom_range(0, COORD_MAX));
                y = int'($urandom_range(0, COORD_MAX));
            end
            push_pixel(x, y);
        end
    endtask

    // Wait until every item has come back, then let the pipeline settle.
    task automatic wait_idle();
        while (pixel_q.size() != 0 || in_valid || src_addr_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        longint inner;
        longint peak;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_go = 1'b0;
        errors = 0;
        cycles = 0;
        sh_cx = 0;
        sh_cy = 0;
        sh_angle = 0;
        sh_inner = 0;
        sh_peak = 0;
        sh_outer = 0;
        sh_width = 640;
        sh_height = 480;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: every pixel maps to itself, bounds at 640 by 480.
        push_pixel(0, 0);
        push_pixel(COORD_MAX, COORD_MAX);
        push_pixel(639, 479);
        push_pixel(640, 479);
        push_pixel(639, 480);
        push_pixel(COORD_MAX, 0);
        push_pixel(0, COORD_MAX);
        wait_idle();

        // Swirl around pixel (100,100): on the centre, on each radius and inside the rising zone.
        write_all(1600, 1600, 32767, 160, 480, 800, 640, 480);
        cfg_write(CFG_IDX_UNUSED, 17'h1FFFF);
        push_pixel(100, 100);
        push_pixel(110, 100);
        push_pixel(120, 100);
        push_pixel(130, 100);
        push_pixel(150, 100);
        push_pixel(90, 100);
        push_pixel(100, 80);
        push_pixel(100, 70);
        push_pixel(105, 103);
        push_pixel(115, 112);
        push_pixel(85, 125);
        wait_idle();

        // Rotation zone with zero angle.
        cfg_write(swp_pkg::CFG_MAX_ANGLE, 0);
        push_pixel(115, 100);
        push_pixel(100, 125);
        push_pixel(92, 108);
        wait_idle();

        // Random phases, some of them at the extremes of the registers.
        for (int ph = 0; ph < 8; ph++)
        begin
            inner = longint'($urandom_range(0, 1600));
            peak = inner + longint'($urandom_range(1, 3000));
            case (ph)
                1: write_all(65535, 65535, -32768, inner, peak, peak + 2000,
                             FIELD_LIM, FIELD_LIM);
                2: write_all(0, 0, 32767, inner, peak,
                             peak + longint'($urandom_range(1, 4000)), 8191, 8191);
                3: write_all(longint'($urandom_range(0, 65535)),
                             longint'($urandom_range(0, 65535)),
                             longint'($urandom_range(0, 65535)), inner, peak, peak + 1500,
                             0, longint'($urandom_range(1, 4096)));
                4: write_all(longint'($urandom_range(0, 65535)),
                             longint'($urandom_range(0, 65535)),
                             longint'($urandom_range(0, 65535)), peak, inner, inner / 2,
                             longint'($urandom_range(1, 4096)), 0);
                5: write_all(32768, 32768, longint'($urandom_range(0, 65535)),
                             0, 131071, 131071, FIELD_LIM, FIELD_LIM);
                default: write_all(longint'($urandom_range(0, 65535)),
                                   longint'($urandom_range(0, 65535)),
                                   longint'($urandom_range(0, 65535)), inner, peak,
                                   peak + longint'($urandom_range(1, 4000)),
                                   longint'($urandom_range(1, 4096)),
                                   longint'($urandom_range(1, 4096)));
            endcase
            if (ph == 6)
            begin
                hold_go = 1'b1;
            end
            push_random_pixels(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
